@@ rtl/core/tlbfl_pkg.sv @@
package tlbfl_pkg;

  // Number of translation slots.
  localparam int unsigned TLB_DEPTH = 16;
  // Slot index width, at least one bit.
  localparam int unsigned IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  // Width of a count that can hold TLB_DEPTH itself.
  localparam int unsigned CNT_W = $clog2(TLB_DEPTH + 1);

  localparam int unsigned AGE_W = 8;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;
  localparam logic [AGE_W-1:0] AGE_ONE = 8'd1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET    = 5'd16;

  // Replacement policies.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] proc_id;
    logic [7:0]  segment_num;
    logic [15:0] page_num;
    logic [15:0] frame_num;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] hit_frame;
    logic        evicted;
    logic [15:0] evicted_proc;
    logic [7:0]  evicted_segment;
    logic [15:0] evicted_page;
    logic [15:0] evicted_frame;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic search;  // register the match and the LRU victim
    logic apply;   // update the entries and load the result register
  } dp_cmd_t;

endpackage

@@ rtl/core/tlbfl_ctrl.sv @@
module tlbfl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlbfl_pkg::dp_cmd_t cmd_o
);
  import tlbfl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.search = (state_q == ST_SEARCH);
    cmd_o.apply  = (state_q == ST_APPLY) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded is replaced,
      // so valid only drops when nothing new arrives.
      if (out_valid_q && out_ready_i && !cmd_o.apply) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/tlbfl_datapath.sv @@
module tlbfl_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tlbfl_pkg::dp_cmd_t                   cmd_i,
  input  tlbfl_pkg::in_item_t                  in_item_i,
  input  logic                                 cfg_we_i,
  input  logic [tlbfl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output tlbfl_pkg::out_item_t                 out_item_o
);
  import tlbfl_pkg::*;

  localparam int unsigned LIM_W  = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int unsigned TREE_N = 1 << IDX_W;

  // Configuration.
  logic                  policy_q;
  logic [CFG_DATA_W-1:0] entries_q;

  // Control state of the buffer.
  logic [TLB_DEPTH-1:0]  valid_q, valid_d;
  logic [AGE_W-1:0]      age_q [TLB_DEPTH];
  logic [AGE_W-1:0]      age_d [TLB_DEPTH];
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [IDX_W-1:0]      oldest_q, oldest_d;

  // Translation payload, no reset.
  logic [15:0] proc_q  [TLB_DEPTH];
  logic [7:0]  seg_q   [TLB_DEPTH];
  logic [15:0] page_q  [TLB_DEPTH];
  logic [15:0] frame_q [TLB_DEPTH];

  in_item_t    item_q;
  logic        hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [IDX_W-1:0] victim_q;
  out_item_t   out_q, out_d;

  logic [CNT_W-1:0] lim;
  logic [LIM_W-1:0] lim_ext;

  // Search results.
  logic [TLB_DEPTH-1:0] match;
  logic                 hit_c;
  logic [IDX_W-1:0]     hit_idx_c;
  logic [AGE_W-1:0]     tr_age [IDX_W+1][TREE_N];
  logic [IDX_W-1:0]     tr_idx [IDX_W+1][TREE_N];

  // Update.
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;
  logic             do_touch;
  logic [IDX_W-1:0] touch_slot;
  logic [IDX_W-1:0] fifo_slot;
  logic [IDX_W-1:0] ins_slot;

  assign out_item_o = out_q;

  // Entry limit clamped to one through the buffer depth.
  always_comb begin
    lim_ext = LIM_W'(entries_q);
    if (lim_ext == '0) begin
      lim_ext = LIM_W'(1);
    end else if (lim_ext > LIM_W'(TLB_DEPTH)) begin
      lim_ext = LIM_W'(TLB_DEPTH);
    end
    lim = lim_ext[CNT_W-1:0];
  end

  // Parallel compare, lowest matching slot wins.
  always_comb begin
    hit_idx_c = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      match[i] = valid_q[i] && (seg_q[i] == item_q.segment_num) &&
                 (page_q[i] == item_q.page_num);
    end
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_c = IDX_W'(i);
      end
    end
    hit_c = |match;
  end

  // Maximum age over the slots below the limit. The left input of each node
  // has the lower index, and it keeps the node unless the right one is
  // strictly older, so ties go to the lowest index.
  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int n = 0; n < TREE_N; n++) begin
        tr_age[l][n] = '0;
        tr_idx[l][n] = '0;
      end
    end
    for (int n = 0; n < TREE_N; n++) begin
      tr_idx[0][n] = IDX_W'(n);
      if ((n < TLB_DEPTH) && (CNT_W'(n) < lim)) begin
        tr_age[0][n] = age_q[n];
      end
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int n = 0; n < TREE_N / 2; n++) begin
        if (tr_age[l][2*n+1] > tr_age[l][2*n]) begin
          tr_age[l+1][n] = tr_age[l][2*n+1];
          tr_idx[l+1][n] = tr_idx[l][2*n+1];
        end else begin
          tr_age[l+1][n] = tr_age[l][2*n];
          tr_idx[l+1][n] = tr_idx[l][2*n];
        end
      end
    end
  end

  // FIFO victim.
  always_comb begin
    fifo_slot = (CNT_W'(oldest_q) < lim) ? oldest_q : '0;
  end

  always_comb begin
    valid_d    = valid_q;
    age_d      = age_q;
    fill_d     = fill_q;
    oldest_d   = oldest_q;
    out_d      = '0;
    wr_en      = 1'b0;
    wr_slot    = '0;
    do_touch   = 1'b0;
    touch_slot = '0;
    ins_slot   = '0;
    case (item_q.command)
      CMD_LOOKUP: begin
        out_d.hit = hit_q;
        if (hit_q) begin
          out_d.hit_frame = frame_q[hit_idx_q];
        end
        do_touch   = hit_q && (policy_q == POLICY_LRU);
        touch_slot = hit_idx_q;
      end
      CMD_INSERT: begin
        if (fill_q < lim) begin
          ins_slot = IDX_W'(fill_q);
          fill_d   = fill_q + CNT_W'(1);
        end else begin
          if (policy_q == POLICY_LRU) begin
            ins_slot = victim_q;
          end else begin
            ins_slot = fifo_slot;
            oldest_d = ((CNT_W'(fifo_slot) + CNT_W'(1)) < lim) ?
                       (fifo_slot + IDX_W'(1)) : '0;
          end
          out_d.evicted         = 1'b1;
          out_d.evicted_proc    = proc_q[ins_slot];
          out_d.evicted_segment = seg_q[ins_slot];
          out_d.evicted_page    = page_q[ins_slot];
          out_d.evicted_frame   = frame_q[ins_slot];
        end
        wr_en   = 1'b1;
        wr_slot = ins_slot;
        valid_d[ins_slot] = 1'b1;
        if (policy_q == POLICY_LRU) begin
          do_touch   = 1'b1;
          touch_slot = ins_slot;
        end else begin
          age_d[ins_slot] = '0;
        end
      end
      CMD_FLUSH: begin
        valid_d  = '0;
        fill_d   = '0;
        oldest_d = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
          age_d[i] = '0;
        end
      end
      default: begin
      end
    endcase
    // A reference makes its slot the youngest and ages every other valid one below the maximum age.
    if (do_touch) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (IDX_W'(i) == touch_slot) begin
          age_d[i] = AGE_ONE;
        end else if (valid_q[i] && (age_q[i] < AGE_MAX)) begin
          age_d[i] = age_q[i] + AGE_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POLICY_FIFO;
      entries_q <= ENTRIES_RESET;
      valid_q   <= '0;
      fill_q    <= '0;
      oldest_q  <= '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REPLACE_POLICY: policy_q  <= cfg_data_i[0];
          CFG_ENTRIES_IN_USE: entries_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.apply) begin
        valid_q  <= valid_d;
        fill_q   <= fill_d;
        oldest_q <= oldest_d;
        age_q    <= age_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.search) begin
      hit_q     <= hit_c;
      hit_idx_q <= hit_idx_c;
      victim_q  <= tr_idx[IDX_W][0];
    end
    if (cmd_i.apply) begin
      out_q <= out_d;
      if (wr_en) begin
        proc_q[wr_slot]  <= item_q.proc_id;
        seg_q[wr_slot]   <= item_q.segment_num;
        page_q[wr_slot]  <= item_q.page_num;
        frame_q[wr_slot] <= item_q.frame_num;
      end
    end
  end

endmodule

@@ rtl/core/tlb_fifo_lru_replacement_top.sv @@
// Each transaction is accepted, then searched, then applied, and the result
// register is loaded at the apply step; a new transaction is accepted
// only once the last one is through. The apply step waits while the result
// register still holds a result that has not been taken.
// Reset: rst_ni is asynchronous and active low; it clears all entries, ages,
// the fill count and the FIFO pointer, and restores FIFO policy, 16 entries.
module tlb_fifo_lru_replacement_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tlbfl_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tlbfl_pkg::out_item_t             out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tlbfl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tlbfl_pkg::*;

  // Command bundle from the controller to the datapath.
  dp_cmd_t dp_cmd;

  // Configuration writes are taken in any cycle; the user must issue them only
  // while idle so an item in flight sees stable settings. This is not enforced.
  assign cfg_ready_o = 1'b1;

  // The controller sequences each transaction through a search step, which
  // registers the match and the LRU victim, and an apply step, which updates
  // the entries and loads the result register.
  tlbfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds the entries, the compare logic, the age tree and the
  // result register.
  tlbfl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

  // An accepted transaction keeps the input closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while a transaction is in progress");

  // A result never reports both a hit and an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.hit && out_item_o.evicted))
    else $error("result shows both hit and eviction");

  // A result without a hit carries a zero frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.hit) |-> (out_item_o.hit_frame == '0))
    else $error("nonzero hit frame without a hit");

  // A result without an eviction carries zero victim fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.evicted) |->
      ((out_item_o.evicted_proc == '0) && (out_item_o.evicted_page == '0) &&
       (out_item_o.evicted_segment == '0) && (out_item_o.evicted_frame == '0)))
    else $error("victim fields set without an eviction");

endmodule
